// ===== src/ttce_pkg.sv =====
// Package for the text terminal cursor engine.
// Holds grid geometry, operation and character codes, and address helpers.
// No dependencies.
package ttce_pkg;

    localparam int TEXT_ROWS = 25;
    localparam int TEXT_COLS = 80;
    localparam int ROW_W = $clog2(TEXT_ROWS);
    localparam int COL_W = $clog2(TEXT_COLS);
    localparam int CELLS = TEXT_ROWS * TEXT_COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_BLINK = 2'd3;

    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_HEX_A = 8'h41 - 8'd10;
    localparam logic [7:0] HI_MASK = 8'hF0;
    localparam logic [7:0] LO_MASK = 8'h0F;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] v;
        v = {4'd0, n};
        return (n > 4'd9) ? v + CH_HEX_A : v + CH_ZERO;
    endfunction

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                   input logic [ROW_W-1:0] base);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, base};
        if (s >= (ROW_W+1)'(TEXT_ROWS))
        begin
            s = s - (ROW_W+1)'(TEXT_ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(TEXT_COLS) + ADDR_W'(c);
    endfunction

endpackage

// ===== src/text_terminal_cursor_engine.sv =====
// Top level of the text terminal cursor engine: cell memory and sequencer.
// Depends on ttce_pkg.
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             operation, char_code, read_row, read_col
// result    out        done (one cycle, no stall) last_of_run ... dirty_left
//
// Bell, backspace, return, refresh and blink give their result in the cycle after the request.
// A read cell is answered from the registered cell data in the S_READ state; each glyph is stored in S_GLYPH.
// A scroll adds a clear of one row of 80 cells; a form feed clears 2000 cells, one per cycle.
// After reset all 2000 cells of the cell memory are cleared while busy is high.
// Scrolling rotates a row base register, so rows are never copied.
module text_terminal_cursor_engine
    import ttce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [4:0] read_row,
    input  logic [6:0] read_col,
    output logic       done,
    output logic       last_of_run,
    output logic       cell_written,
    output logic [7:0] cell_char,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col,
    output logic       cursor_shown,
    output logic       cursor_needs_redraw,
    output logic       scrolled,
    output logic       dirty_valid,
    output logic [4:0] dirty_top,
    output logic [4:0] dirty_bottom,
    output logic [6:0] dirty_left
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_GLYPH = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [7:0] mem [CELLS];
    logic [7:0] rdata_reg;
    logic we;
    logic [ADDR_W-1:0] waddr, raddr;

    logic [1:0] state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next, base_reg, base_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic blink_reg, blink_next, redraw_reg, redraw_next;
    logic rv_reg, rv_next;
    logic [ROW_W-1:0] rt_reg, rt_next, rb_reg, rb_next;
    logic [COL_W-1:0] rl_reg, rl_next, rr_reg, rr_next;
    logic [ROW_W-1:0] sw_row_reg, sw_row_next;
    logic [COL_W-1:0] sw_col_reg, sw_col_next;
    logic sw_all_reg, sw_all_next, sw_emit_reg, sw_emit_next;
    logic pend_last_reg, pend_last_next, pend_written_reg, pend_written_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic pend_sc_reg, pend_sc_next;
    logic [7:0] code_reg, code_next;
    logic multi_reg, multi_next;
    logic [2:0] gidx_reg, gidx_next;
    logic rd_ok_reg, rd_ok_next;

    logic emit;
    logic e_last, e_written, e_sc, e_redraw, e_rv;
    logic [7:0] e_char;
    logic [ROW_W-1:0] e_rt, e_rb;
    logic [COL_W-1:0] e_rl;

    logic done_reg, last_reg, written_reg, sc_reg, shown_reg, redraw_o_reg, dv_reg;
    logic [7:0] char_reg;
    logic [4:0] orow_reg, otop_reg, obot_reg;
    logic [6:0] ocol_reg, oleft_reg;

    logic [7:0] glyph;
    logic [7:0] wdata;

    always_comb
    begin
        case (gidx_reg)
            3'd0: glyph = CH_LBR;
            3'd1: glyph = hex_digit(4'((code_reg & HI_MASK) >> 4));
            3'd2: glyph = hex_digit(4'(code_reg & LO_MASK));
            3'd3: glyph = CH_RBR;
            default: glyph = CH_STAR;
        endcase
        if (!multi_reg)
        begin
            glyph = code_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        base_next = base_reg;
        blink_next = blink_reg;
        redraw_next = redraw_reg;
        rv_next = rv_reg;
        rt_next = rt_reg;
        rb_next = rb_reg;
        rl_next = rl_reg;
        rr_next = rr_reg;
        sw_row_next = sw_row_reg;
        sw_col_next = sw_col_reg;
        sw_all_next = sw_all_reg;
        sw_emit_next = sw_emit_reg;
        pend_last_next = pend_last_reg;
        pend_written_next = pend_written_reg;
        pend_char_next = pend_char_reg;
        pend_sc_next = pend_sc_reg;
        code_next = code_reg;
        multi_next = multi_reg;
        gidx_next = gidx_reg;
        rd_ok_next = rd_ok_reg;
        emit = 1'b0;
        e_last = 1'b1;
        e_written = 1'b0;
        e_char = 8'd0;
        e_sc = 1'b0;
        we = 1'b0;
        waddr = cell_addr(phys_row(row_reg, base_reg), col_reg);
        wdata = 8'd0;
        raddr = cell_addr(phys_row(ROW_W'(read_row), base_reg), COL_W'(read_col));

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_READ:
                        begin
                            rd_ok_next = (read_row < 5'(TEXT_ROWS)) && (read_col < 7'(TEXT_COLS));
                            state_next = S_READ;
                        end
                        OP_REFRESH:
                        begin
                            emit = 1'b1;
                            rv_next = 1'b0;
                            rt_next = '0;
                            rb_next = '0;
                            rl_next = '0;
                            rr_next = '0;
                            redraw_next = 1'b0;
                        end
                        OP_BLINK:
                        begin
                            emit = 1'b1;
                            blink_next = !blink_reg;
                            redraw_next = 1'b1;
                        end
                        default:
                        begin
                            case (char_code)
                                CH_BEL:
                                begin
                                    emit = 1'b1;
                                end
                                CH_BS, CH_CR, CH_NL:
                                begin
                                    if (blink_reg)
                                    begin
                                        if (!rv_reg)
                                        begin
                                            rv_next = 1'b1;
                                            rt_next = row_reg;
                                            rb_next = row_reg;
                                            rl_next = col_reg;
                                            rr_next = col_reg;
                                        end
                                        else
                                        begin
                                            if (row_reg < rt_reg) rt_next = row_reg;
                                            if (row_reg > rb_reg) rb_next = row_reg;
                                            if (col_reg < rl_reg) rl_next = col_reg;
                                            if (col_reg > rr_reg) rr_next = col_reg;
                                        end
                                    end
                                    if (char_code == CH_NL)
                                    begin
                                        if (row_reg == ROW_W'(TEXT_ROWS - 1))
                                        begin
                                            base_next = (base_reg == ROW_W'(TEXT_ROWS - 1)) ?
                                                        '0 : base_reg + 1'b1;
                                            rv_next = 1'b1;
                                            rt_next = '0;
                                            rl_next = '0;
                                            rb_next = ROW_W'(TEXT_ROWS - 1);
                                            rr_next = COL_W'(TEXT_COLS - 1);
                                            sw_row_next = base_reg;
                                            sw_col_next = '0;
                                            sw_all_next = 1'b0;
                                            sw_emit_next = 1'b1;
                                            pend_last_next = 1'b1;
                                            pend_written_next = 1'b0;
                                            pend_char_next = 8'd0;
                                            pend_sc_next = 1'b1;
                                            state_next = S_SWEEP;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + 1'b1;
                                            emit = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        redraw_next = redraw_reg | blink_reg;
                                        emit = 1'b1;
                                        if (char_code == CH_CR)
                                        begin
                                            col_next = '0;
                                        end
                                        else if (col_reg != '0)
                                        begin
                                            col_next = col_reg - 1'b1;
                                        end
                                    end
                                end
                                CH_FF:
                                begin
                                    row_next = '0;
                                    col_next = '0;
                                    rv_next = 1'b1;
                                    rt_next = '0;
                                    rl_next = '0;
                                    rb_next = ROW_W'(TEXT_ROWS - 1);
                                    rr_next = COL_W'(TEXT_COLS - 1);
                                    redraw_next = redraw_reg | blink_reg;
                                    sw_row_next = '0;
                                    sw_col_next = '0;
                                    sw_all_next = 1'b1;
                                    sw_emit_next = 1'b1;
                                    pend_last_next = 1'b1;
                                    pend_written_next = 1'b0;
                                    pend_char_next = 8'd0;
                                    pend_sc_next = 1'b0;
                                    state_next = S_SWEEP;
                                end
                                default:
                                begin
                                    code_next = char_code;
                                    multi_next = !(char_code inside {[CH_SPACE:CH_TILDE]});
                                    gidx_next = 3'd0;
                                    state_next = S_GLYPH;
                                end
                            endcase
                        end
                    endcase
                end
            end
            S_READ:
            begin
                emit = 1'b1;
                e_char = rd_ok_reg ? rdata_reg : 8'd0;
                state_next = S_IDLE;
            end
            S_GLYPH:
            begin
                we = 1'b1;
                wdata = glyph;
                if (!rv_reg)
                begin
                    rv_next = 1'b1;
                    rt_next = row_reg;
                    rb_next = row_reg;
                    rl_next = col_reg;
                    rr_next = col_reg;
                end
                else
                begin
                    if (row_reg < rt_reg) rt_next = row_reg;
                    if (row_reg > rb_reg) rb_next = row_reg;
                    if (col_reg < rl_reg) rl_next = col_reg;
                    if (col_reg > rr_reg) rr_next = col_reg;
                end
                redraw_next = redraw_reg | blink_reg;
                gidx_next = gidx_reg + 1'b1;
                e_last = !multi_reg || (gidx_reg == 3'd4);
                e_written = 1'b1;
                e_char = glyph;
                if (col_reg == COL_W'(TEXT_COLS - 1))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(TEXT_ROWS - 1))
                    begin
                        base_next = (base_reg == ROW_W'(TEXT_ROWS - 1)) ? '0 : base_reg + 1'b1;
                        rv_next = 1'b1;
                        rt_next = '0;
                        rl_next = '0;
                        rb_next = ROW_W'(TEXT_ROWS - 1);
                        rr_next = COL_W'(TEXT_COLS - 1);
                        sw_row_next = base_reg;
                        sw_col_next = '0;
                        sw_all_next = 1'b0;
                        sw_emit_next = 1'b1;
                        pend_last_next = e_last;
                        pend_written_next = 1'b1;
                        pend_char_next = glyph;
                        pend_sc_next = 1'b1;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                if (state_next != S_SWEEP)
                begin
                    emit = 1'b1;
                    state_next = e_last ? S_IDLE : S_GLYPH;
                end
            end
            default:
            begin
                we = 1'b1;
                waddr = cell_addr(sw_row_reg, sw_col_reg);
                wdata = 8'd0;
                if (sw_col_reg == COL_W'(TEXT_COLS - 1))
                begin
                    sw_col_next = '0;
                    if (sw_all_reg && sw_row_reg != ROW_W'(TEXT_ROWS - 1))
                    begin
                        sw_row_next = sw_row_reg + 1'b1;
                    end
                    else
                    begin
                        emit = sw_emit_reg;
                        e_last = pend_last_reg;
                        e_written = pend_written_reg;
                        e_char = pend_char_reg;
                        e_sc = pend_sc_reg;
                        state_next = (sw_emit_reg && !pend_last_reg) ? S_GLYPH : S_IDLE;
                    end
                end
                else
                begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
        endcase

        e_redraw = redraw_next;
        e_rv = rv_next;
        e_rt = rt_next;
        e_rb = rb_next;
        e_rl = rl_next;
        if (state_reg == S_IDLE && operation == OP_REFRESH)
        begin
            e_rv = rv_reg;
            e_rt = rt_reg;
            e_rb = rb_reg;
            e_rl = rl_reg;
            e_redraw = redraw_reg | (blink_reg & rv_reg &&
                       row_reg >= rt_reg && row_reg <= rb_reg &&
                       col_reg >= rl_reg && col_reg <= rr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            row_reg <= '0;
            col_reg <= '0;
            base_reg <= '0;
            blink_reg <= 1'b0;
            redraw_reg <= 1'b0;
            rv_reg <= 1'b0;
            rt_reg <= '0;
            rb_reg <= '0;
            rl_reg <= '0;
            rr_reg <= '0;
            sw_row_reg <= '0;
            sw_col_reg <= '0;
            sw_all_reg <= 1'b1;
            sw_emit_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            base_reg <= base_next;
            blink_reg <= blink_next;
            redraw_reg <= redraw_next;
            rv_reg <= rv_next;
            rt_reg <= rt_next;
            rb_reg <= rb_next;
            rl_reg <= rl_next;
            rr_reg <= rr_next;
            sw_row_reg <= sw_row_next;
            sw_col_reg <= sw_col_next;
            sw_all_reg <= sw_all_next;
            sw_emit_reg <= sw_emit_next;
            done_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_last_reg <= pend_last_next;
        pend_written_reg <= pend_written_next;
        pend_char_reg <= pend_char_next;
        pend_sc_reg <= pend_sc_next;
        code_reg <= code_next;
        multi_reg <= multi_next;
        gidx_reg <= gidx_next;
        rd_ok_reg <= rd_ok_next;
        if (emit)
        begin
            last_reg <= e_last;
            written_reg <= e_written;
            char_reg <= e_char;
            orow_reg <= 5'(row_next);
            ocol_reg <= 7'(col_next);
            shown_reg <= blink_next;
            redraw_o_reg <= e_redraw;
            sc_reg <= e_sc;
            dv_reg <= e_rv;
            otop_reg <= 5'(e_rt);
            obot_reg <= 5'(e_rb);
            oleft_reg <= 7'(e_rl);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign last_of_run = last_reg;
    assign cell_written = written_reg;
    assign cell_char = char_reg;
    assign cursor_row = orow_reg;
    assign cursor_col = ocol_reg;
    assign cursor_shown = shown_reg;
    assign cursor_needs_redraw = redraw_o_reg;
    assign scrolled = sc_reg;
    assign dirty_valid = dv_reg;
    assign dirty_top = otop_reg;
    assign dirty_bottom = obot_reg;
    assign dirty_left = oleft_reg;

`ifndef NO_ASSERTIONS
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < ROW_W'(TEXT_ROWS) && base_reg < ROW_W'(TEXT_ROWS))
        else $error("cursor row or row base out of range");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(TEXT_COLS))
        else $error("cursor column out of range");
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_of_run |-> busy)
        else $error("request finished before its last result");
    a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (rt_reg <= rb_reg && rl_reg <= rr_reg))
        else $error("dirty rectangle inverted");
`endif

endmodule

// ===== tb/text_terminal_cursor_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text terminal cursor engine.
// Holds a behavioral model of the grid, cursor and dirty rectangle; depends on ttce_pkg.
module text_terminal_cursor_engine_tb;
    import ttce_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [1:0] op;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
        bit         drain;
    } term_request_t;

    typedef struct {
        logic       last;
        logic       written;
        logic [7:0] ch;
        logic [4:0] crow;
        logic [6:0] ccol;
        logic       shown;
        logic       redraw;
        logic       scr;
        logic       dv;
        logic [4:0] dt;
        logic [4:0] db;
        logic [6:0] dl;
    } term_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] operation = OP_PUT;
    logic [7:0] char_code = 8'd0;
    logic [4:0] read_row = 5'd0;
    logic [6:0] read_col = 7'd0;
    logic       busy, done, last_of_run, cell_written, cursor_shown;
    logic       cursor_needs_redraw, scrolled, dirty_valid;
    logic [7:0] cell_char;
    logic [4:0] cursor_row, dirty_top, dirty_bottom;
    logic [6:0] cursor_col, dirty_left;

    term_request_t pending_requests[$];
    term_result_t  awaited_results[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_left = 0;
    bit   no_idle = 1'b0;
    logic taken = 1'b0;

    logic [7:0] grid [TEXT_ROWS][TEXT_COLS];
    int crow = 0, ccol = 0, rtop = 0, rbot = 0, rleft = 0, rright = 0;
    bit phase = 0, redraw = 0, rvalid = 0;

    text_terminal_cursor_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .char_code(char_code),
        .read_row(read_row), .read_col(read_col),
        .done(done), .last_of_run(last_of_run), .cell_written(cell_written),
        .cell_char(cell_char), .cursor_row(cursor_row), .cursor_col(cursor_col),
        .cursor_shown(cursor_shown), .cursor_needs_redraw(cursor_needs_redraw),
        .scrolled(scrolled), .dirty_valid(dirty_valid), .dirty_top(dirty_top),
        .dirty_bottom(dirty_bottom), .dirty_left(dirty_left)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic mark_dirty(input int r, input int c);
        if (!rvalid)
        begin
            rvalid = 1;
            rtop = r;
            rbot = r;
            rleft = c;
            rright = c;
        end
        else
        begin
            if (r < rtop) rtop = r;
            if (r > rbot) rbot = r;
            if (c < rleft) rleft = c;
            if (c > rright) rright = c;
        end
    endtask

    task automatic whole_screen_dirty();
        rvalid = 1;
        rtop = 0;
        rleft = 0;
        rbot = TEXT_ROWS - 1;
        rright = TEXT_COLS - 1;
    endtask

    task automatic scroll_grid();
        for (int r = 0; r < TEXT_ROWS - 1; r++)
            for (int c = 0; c < TEXT_COLS; c++)
                grid[r][c] = grid[r + 1][c];
        for (int c = 0; c < TEXT_COLS; c++)
            grid[TEXT_ROWS - 1][c] = 8'd0;
        whole_screen_dirty();
    endtask

    task automatic add_result(input bit last, input bit written, input logic [7:0] ch,
                              input bit scr);
        term_result_t res;
        res.last = last;
        res.written = written;
        res.ch = ch;
        res.crow = 5'(crow);
        res.ccol = 7'(ccol);
        res.shown = phase;
        res.redraw = redraw;
        res.scr = scr;
        res.dv = rvalid;
        res.dt = rvalid ? 5'(rtop) : 5'd0;
        res.db = rvalid ? 5'(rbot) : 5'd0;
        res.dl = rvalid ? 7'(rleft) : 7'd0;
        awaited_results.push_back(res);
    endtask

    task automatic store_glyph(input logic [7:0] ch, input bit last);
        bit sc;
        sc = 0;
        grid[crow][ccol] = ch;
        mark_dirty(crow, ccol);
        ccol++;
        if (ccol >= TEXT_COLS)
        begin
            ccol = 0;
            crow++;
            if (crow >= TEXT_ROWS)
            begin
                scroll_grid();
                crow = TEXT_ROWS - 1;
                sc = 1;
            end
        end
        redraw |= phase;
        add_result(last, 1, ch, sc);
    endtask

    function automatic logic [7:0] hex_glyph(input logic [3:0] n);
        return (n > 4'd9) ? 8'(n) + CH_HEX_A : 8'(n) + CH_ZERO;
    endfunction

    task automatic predict_terminal(input term_request_t rq);
        logic [7:0] v;
        bit sc;
        sc = 0;
        case (rq.op)
            OP_READ:
            begin
                v = (rq.row < TEXT_ROWS && rq.col < TEXT_COLS) ? grid[rq.row][rq.col] : 8'd0;
                add_result(1, 0, v, 0);
            end
            OP_REFRESH:
            begin
                if (rvalid && crow >= rtop && crow <= rbot && ccol >= rleft && ccol <= rright)
                    redraw |= phase;
                add_result(1, 0, 8'd0, 0);
                redraw = 0;
                rvalid = 0;
                rtop = 0;
                rbot = 0;
                rleft = 0;
                rright = 0;
            end
            OP_BLINK:
            begin
                phase ^= 1;
                redraw = 1;
                add_result(1, 0, 8'd0, 0);
            end
            default:
            begin
                case (rq.code)
                    CH_BEL: add_result(1, 0, 8'd0, 0);
                    CH_BS, CH_CR:
                    begin
                        if (phase) mark_dirty(crow, ccol);
                        if (rq.code == CH_CR) ccol = 0;
                        else if (ccol > 0) ccol--;
                        redraw |= phase;
                        add_result(1, 0, 8'd0, 0);
                    end
                    CH_NL:
                    begin
                        if (phase) mark_dirty(crow, ccol);
                        crow++;
                        if (crow >= TEXT_ROWS)
                        begin
                            scroll_grid();
                            crow = TEXT_ROWS - 1;
                            sc = 1;
                        end
                        add_result(1, 0, 8'd0, sc);
                    end
                    CH_FF:
                    begin
                        for (int r = 0; r < TEXT_ROWS; r++)
                            for (int c = 0; c < TEXT_COLS; c++)
                                grid[r][c] = 8'd0;
                        crow = 0;
                        ccol = 0;
                        whole_screen_dirty();
                        redraw |= phase;
                        add_result(1, 0, 8'd0, 0);
                    end
                    default:
                    begin
                        if (rq.code >= CH_SPACE && rq.code <= CH_TILDE)
                            store_glyph(rq.code, 1);
                        else
                        begin
                            store_glyph(CH_LBR, 0);
                            store_glyph(hex_glyph(4'((rq.code & HI_MASK) >> 4)), 0);
                            store_glyph(hex_glyph(4'(rq.code & LO_MASK)), 0);
                            store_glyph(CH_RBR, 0);
                            store_glyph(CH_STAR, 1);
                        end
                    end
                endcase
            end
        endcase
    endtask

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            mismatches++;
            $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        term_result_t w;
        term_request_t rq;
        cycles++;
        taken <= start && !busy;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                report("unexpected result", 8'd1, 8'd0);
            end
            else
            begin
                w = awaited_results.pop_front();
                report("last_of_run", 8'(last_of_run), 8'(w.last));
                report("cell_written", 8'(cell_written), 8'(w.written));
                report("cell_char", cell_char, w.ch);
                report("cursor_row", 8'(cursor_row), 8'(w.crow));
                report("cursor_col", 8'(cursor_col), 8'(w.ccol));
                report("cursor_shown", 8'(cursor_shown), 8'(w.shown));
                report("cursor_needs_redraw", 8'(cursor_needs_redraw), 8'(w.redraw));
                report("scrolled", 8'(scrolled), 8'(w.scr));
                report("dirty_valid", 8'(dirty_valid), 8'(w.dv));
                report("dirty_top", 8'(dirty_top), 8'(w.dt));
                report("dirty_bottom", 8'(dirty_bottom), 8'(w.db));
                report("dirty_left", 8'(dirty_left), 8'(w.dl));
            end
        end
        if (rst_n && start && !busy)
        begin
            rq.op = operation;
            rq.code = char_code;
            rq.row = read_row;
            rq.col = read_col;
            rq.drain = 0;
            predict_terminal(rq);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** text_terminal_cursor_engine: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        term_request_t rq;
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].drain || awaited_results.size() == 0))
            begin
                rq = pending_requests.pop_front();
                operation <= rq.op;
                char_code <= rq.code;
                read_row <= rq.row;
                read_col <= rq.col;
                start <= 1'b1;
                if ($urandom_range(0, 29) == 0) no_idle <= !no_idle;
                gap_left <= no_idle ? 0 : $urandom_range(0, 12);
            end
            else
                start <= 1'b0;
        end
    end

    task automatic add_request(input logic [1:0] op, input logic [7:0] code,
                               input logic [4:0] row, input logic [6:0] col,
                               input bit drain);
        term_request_t rq;
        rq.op = op;
        rq.code = code;
        rq.row = row;
        rq.col = col;
        rq.drain = drain;
        pending_requests.push_back(rq);
    endtask

    initial
    begin
        int n, pick, burst;
        for (int r = 0; r < TEXT_ROWS; r++)
            for (int c = 0; c < TEXT_COLS; c++)
                grid[r][c] = 8'd0;

        add_request(OP_READ, 8'd0, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_BEL, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_BS, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_SPACE, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_TILDE, 5'd0, 7'd0, 0);
        add_request(OP_PUT, 8'h00, 5'd0, 7'd0, 0);
        add_request(OP_PUT, 8'hFF, 5'd0, 7'd0, 0);
        add_request(OP_READ, 8'd0, 5'd0, 7'd1, 0);
        add_request(OP_READ, 8'd0, 5'd24, 7'd79, 0);
        add_request(OP_READ, 8'd0, 5'd31, 7'd127, 0);
        add_request(OP_PUT, CH_CR, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_NL, 5'd0, 7'd0, 0);
        add_request(OP_REFRESH, 8'd0, 5'd0, 7'd0, 0);
        add_request(OP_REFRESH, 8'd0, 5'd0, 7'd0, 0);
        add_request(OP_BLINK, 8'd0, 5'd0, 7'd0, 1);
        add_request(OP_PUT, CH_BS, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_NL, 5'd0, 7'd0, 0);
        add_request(OP_PUT, 8'h41, 5'd0, 7'd0, 0);
        add_request(OP_REFRESH, 8'd0, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_FF, 5'd0, 7'd0, 0);
        add_request(OP_READ, 8'd0, 5'd1, 7'd0, 0);
        add_request(OP_BLINK, 8'd0, 5'd0, 7'd0, 0);
        add_request(OP_PUT, CH_CR, 5'd0, 7'd0, 0);
        add_request(OP_REFRESH, 8'd0, 5'd0, 7'd0, 0);

        n = 0;
        while (n < 146)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                burst = $urandom_range(3, 9);
                for (int k = 0; k < burst; k++)
                    add_request(OP_PUT, CH_NL, 5'($urandom), 7'($urandom), 0);
                n += burst;
            end
            else
            begin
                if (pick < 45)
                    add_request(OP_PUT, 8'($urandom_range(32, 126)), 5'($urandom),
                                7'($urandom), 0);
                else if (pick < 55)
                    add_request(OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom), 0);
                else if (pick < 66)
                begin
                    case ($urandom_range(0, 20))
                        0: add_request(OP_PUT, CH_FF, 5'd0, 7'd0, 0);
                        1, 2, 3, 4: add_request(OP_PUT, CH_BEL, 5'd0, 7'd0, 0);
                        5, 6, 7, 8, 9: add_request(OP_PUT, CH_BS, 5'd0, 7'd0, 0);
                        10, 11, 12, 13, 14: add_request(OP_PUT, CH_CR, 5'd0, 7'd0, 0);
                        default: add_request(OP_PUT, CH_NL, 5'd0, 7'd0, 0);
                    endcase
                end
                else if (pick < 80)
                begin
                    if ($urandom_range(0, 3) == 0)
                        add_request(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom), 0);
                    else
                        add_request(OP_READ, 8'($urandom), 5'($urandom_range(0, 24)),
                                    7'($urandom_range(0, 79)), 0);
                end
                else if (pick < 90)
                    add_request(OP_REFRESH, 8'($urandom), 5'($urandom), 7'($urandom),
                                $urandom_range(0, 5) == 0);
                else
                    add_request(OP_BLINK, 8'($urandom), 5'($urandom), 7'($urandom), 0);
                n++;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(negedge clk);
        while (pending_requests.size() != 0 || start || awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("** text_terminal_cursor_engine: PASSED **");
        else
            $display("** text_terminal_cursor_engine: FAILED **");
        $finish;
    end
endmodule
